// ===== hw/rtl/scd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_pkg
// shared types and constants of the su3 complex dot product core
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int unsigned FRAC_BITS_DEF = 24;
  localparam int unsigned PART_W        = 32;
  localparam int unsigned PROD_W        = 2 * PART_W;
  localparam int unsigned TERM_W        = PROD_W + 1;
  localparam int unsigned SUM_W         = PROD_W + 2;
  localparam int unsigned NUM_TERMS     = 3;

  // input word, each complex entry is real in 63:32 and imaginary in 31:0
  typedef struct packed {
    logic [63:0] link_0;
    logic [63:0] link_1;
    logic [63:0] link_2;
    logic [63:0] vec_0;
    logic [63:0] vec_1;
    logic [63:0] vec_2;
    logic        last_item;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    logic               saturated;
    logic               last_out;
  } out_word_t;

  // four partial products of one complex term
  typedef struct packed {
    logic signed [PROD_W-1:0] rr;
    logic signed [PROD_W-1:0] ii;
    logic signed [PROD_W-1:0] ri;
    logic signed [PROD_W-1:0] ir;
  } cprod_t;

  typedef struct packed {
    cprod_t [NUM_TERMS-1:0] term;
    logic                   adj;
    logic                   last;
  } prod_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] re;
    logic signed [SUM_W-1:0] im;
    logic                    last;
  } sum_word_t;

endpackage

// ===== hw/rtl/su3_complex_dot_product_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// su3_complex_dot_product_core
// one complex element of U*v or U^dagger*v from three link entries and
// three vector entries, Q-format fixed point, rounded and saturated
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | in_valid_i/in_stall_o   | in_word_i  (scd_pkg::in_word_t)
//  out     | output    | out_valid_o/out_stall_i | out_word_o (scd_pkg::out_word_t)
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (adjoint mode)
//
//  one word accepted per cycle unless the pipeline backs up, four register
//  stages; a result word is valid once it is held in the last of them
//  stages: multiply, per-term combine, three-term sum, round/saturate
//  each stage holds while its successor is full and stalled; bubbles
//  close up, so words keep entering while a result waits at the output
//  reset clears valid bits and adjoint mode (plain mode)
//
module su3_complex_dot_product_core #(
  parameter int unsigned FracBits = scd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  scd_pkg::in_word_t  in_word_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output scd_pkg::out_word_t out_word_o,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i
);

  // adjoint mode register
  logic adj_q;

  // stage handshakes
  logic                mult_take, mult_valid;
  scd_pkg::prod_word_t mult_word;
  logic                sum_take, sum_valid;
  scd_pkg::sum_word_t  sum_word;
  logic                rnd_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q <= 1'b0;
    end else if (cfg_we_i) begin
      adj_q <= cfg_wdata_i;
    end
  end

  // mode travels with the word from the first stage on
  scd_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .adj_i   (adj_q),
    .take_o  (mult_take),
    .valid_o (mult_valid),
    .word_o  (mult_word),
    .adv_i   (sum_take)
  );

  // exact 66-bit sums, no rounding yet
  scd_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mult_valid),
    .word_i  (mult_word),
    .take_o  (sum_take),
    .valid_o (sum_valid),
    .word_o  (sum_word),
    .adv_i   (rnd_take)
  );

  // round half up, clip, output register
  scd_round #(
    .FracBits (FracBits)
  ) u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .word_i  (sum_word),
    .take_o  (rnd_take),
    .valid_o (out_valid_o),
    .word_o  (out_word_o),
    .stall_i (out_stall_i)
  );

  assign in_stall_o = !mult_take;

endmodule

// ===== hw/rtl/scd_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_mult
// multiplier stage: twelve registered 32x32 signed products
// ----------------------------------------------------------------------------
module scd_mult (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  scd_pkg::in_word_t   word_i,
  input  logic                adj_i,
  output logic                take_o,
  output logic                valid_o,
  output scd_pkg::prod_word_t word_o,
  input  logic                adv_i
);

  logic                valid_q;
  scd_pkg::prod_word_t word_q, word_d;
  logic [63:0]         link [scd_pkg::NUM_TERMS];
  logic [63:0]         vec  [scd_pkg::NUM_TERMS];

  assign link[0] = word_i.link_0;
  assign link[1] = word_i.link_1;
  assign link[2] = word_i.link_2;
  assign vec[0]  = word_i.vec_0;
  assign vec[1]  = word_i.vec_1;
  assign vec[2]  = word_i.vec_2;

  always_comb begin
    logic signed [31:0] lr, li, vr, vi;
    word_d      = '0;
    word_d.adj  = adj_i;
    word_d.last = word_i.last_item;
    for (int k = 0; k < scd_pkg::NUM_TERMS; k++) begin
      lr = $signed(link[k][63:32]);
      li = $signed(link[k][31:0]);
      vr = $signed(vec[k][63:32]);
      vi = $signed(vec[k][31:0]);
      word_d.term[k].rr = 64'(lr) * 64'(vr);
      word_d.term[k].ii = 64'(li) * 64'(vi);
      word_d.term[k].ri = 64'(lr) * 64'(vi);
      word_d.term[k].ir = 64'(li) * 64'(vr);
    end
  end

  assign take_o = !valid_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== hw/rtl/scd_sum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_sum
// two adder stages: per-term complex combine, then sum of the three terms
// ----------------------------------------------------------------------------
module scd_sum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  scd_pkg::prod_word_t word_i,
  output logic                take_o,
  output logic                valid_o,
  output scd_pkg::sum_word_t  word_o,
  input  logic                adv_i
);

  localparam int unsigned TW = scd_pkg::TERM_W;
  localparam int unsigned SW = scd_pkg::SUM_W;
  localparam int unsigned PW = scd_pkg::PROD_W;

  // stage a: one complex term each
  logic                 a_valid_q;
  logic signed [TW-1:0] a_re_q [scd_pkg::NUM_TERMS];
  logic signed [TW-1:0] a_im_q [scd_pkg::NUM_TERMS];
  logic                 a_last_q;
  logic                 a_take;

  // stage b: total
  logic                 b_valid_q;
  scd_pkg::sum_word_t   b_word_q, b_word_d;
  logic                 b_take;

  assign b_take = !b_valid_q || adv_i;
  assign a_take = !a_valid_q || b_take;
  assign take_o = a_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_take) a_valid_q <= valid_i;
      if (b_take) b_valid_q <= a_valid_q;
    end
  end

  // adjoint conjugates the link entry: re = rr + ii, im = ri - ir
  always_ff @(posedge clk_i) begin
    if (a_take && valid_i) begin
      for (int k = 0; k < scd_pkg::NUM_TERMS; k++) begin
        if (word_i.adj) begin
          a_re_q[k] <= TW'(word_i.term[k].rr) + TW'(word_i.term[k].ii);
          a_im_q[k] <= TW'(word_i.term[k].ri) - TW'(word_i.term[k].ir);
        end else begin
          a_re_q[k] <= TW'(word_i.term[k].rr) - TW'(word_i.term[k].ii);
          a_im_q[k] <= TW'(word_i.term[k].ri) + TW'(word_i.term[k].ir);
        end
      end
      a_last_q <= word_i.last;
    end
  end

  always_comb begin
    b_word_d.re   = SW'(a_re_q[0]) + SW'(a_re_q[1]) + SW'(a_re_q[2]);
    b_word_d.im   = SW'(a_im_q[0]) + SW'(a_im_q[1]) + SW'(a_im_q[2]);
    b_word_d.last = a_last_q;
  end

  always_ff @(posedge clk_i) begin
    if (b_take && a_valid_q) begin
      b_word_q <= b_word_d;
    end
  end

  assign valid_o = b_valid_q;
  assign word_o  = b_word_q;

  // products are PW bits, sign extension to the term width above
  if (PW + 1 != TW) begin : g_width_check
    $error("term width must be one bit over the product width");
  end

endmodule

// ===== hw/rtl/scd_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_round
// output stage: round to nearest, saturate to 32 bits, output register
// ----------------------------------------------------------------------------
module scd_round #(
  parameter int unsigned FracBits = scd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  scd_pkg::sum_word_t word_i,
  output logic               take_o,
  output logic               valid_o,
  output scd_pkg::out_word_t word_o,
  input  logic               stall_i
);

  localparam int unsigned RW = scd_pkg::SUM_W + 1;
  localparam logic [RW-1:0] Half = RW'(1) << (FracBits - 1);

  logic              valid_q;
  scd_pkg::out_word_t word_q, word_d;

  function automatic logic [32:0] round_sat(input logic signed [scd_pkg::SUM_W-1:0] v);
    logic signed [RW-1:0] rnd;
    logic signed [RW-1:0] sh;
    logic                 ovf;
    rnd = RW'(v) + $signed(Half);
    sh  = rnd >>> FracBits;
    ovf = !((&sh[RW-1:31]) || !(|sh[RW-1:31]));
    if (!ovf) begin
      round_sat = {1'b0, sh[31:0]};
    end else if (sh[RW-1]) begin
      round_sat = {1'b1, 32'h8000_0000};
    end else begin
      round_sat = {1'b1, 32'h7FFF_FFFF};
    end
  endfunction

  always_comb begin
    logic [32:0] r_re, r_im;
    r_re             = round_sat(word_i.re);
    r_im             = round_sat(word_i.im);
    word_d.out_re    = $signed(r_re[31:0]);
    word_d.out_im    = $signed(r_im[31:0]);
    word_d.saturated = r_re[32] | r_im[32];
    word_d.last_out  = word_i.last;
  end

  assign take_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for su3_complex_dot_product_core: directed corner words
// and random words in plain and adjoint mode are predicted in a scoreboard
// and every result word is compared field by field, with random gaps on both
// sides, a long output hold-off and drains between mode changes
// ----------------------------------------------------------------------------
module testbench;

  // timing and sizing of the run
  localparam int unsigned FRAC           = scd_pkg::FRAC_BITS_DEF;
  localparam int unsigned LAT            = 4;     // pipeline depth of the core
  localparam int unsigned RAND_PER_PHASE = 316;   // six random phases
  localparam int unsigned LONG_HOLD      = 80;    // output hold-off in cycles
  localparam int          ONE_I          = 1 << FRAC;
  localparam int          HALF_I         = 1 << (FRAC - 1);

  // mode plan of the random phases, both extremes and repeated writes
  localparam bit PLAN [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  scd_pkg::in_word_t  in_word_i;
  logic               out_valid_o;
  logic               out_stall_i;
  scd_pkg::out_word_t out_word_o;
  logic               cfg_we_i;
  logic               cfg_wdata_i;

  // shared control between the main sequence and the two drivers
  bit adj_mode  = 1'b0;   // mode the core holds, only changed while idle
  bit no_idle   = 1'b0;   // stretch with no gaps on either side
  bit hold_req  = 1'b0;   // asks the receiver for one long hold-off

  // --------------------------------------------------------------------------
  // scoreboard: predicts each accepted input word and checks result words
  // --------------------------------------------------------------------------
  class dot_scoreboard;
    scd_pkg::out_word_t expected_q[$];
    int unsigned        mismatches = 0;
    int unsigned        failures   = 0;

    // round half up to FRAC fraction bits, then clip to a signed 32-bit part
    function logic [31:0] round_clip(input logic signed [127:0] acc, inout bit clip);
      logic signed [127:0] half;
      logic signed [127:0] r;
      logic signed [127:0] max_part;
      logic signed [127:0] min_part;
      half     = 128'sd1 <<< (FRAC - 1);
      max_part = 128'sh7fff_ffff;
      min_part = -128'sh8000_0000;
      r = (acc + half) >>> FRAC;
      if (r > max_part) begin
        clip = 1'b1;
        return 32'h7fff_ffff;
      end
      if (r < min_part) begin
        clip = 1'b1;
        return 32'h8000_0000;
      end
      return r[31:0];
    endfunction

    // sum of three complex products, link conjugated in adjoint mode
    function scd_pkg::out_word_t su3_dot(scd_pkg::in_word_t w, bit adj);
      logic [63:0]         lk [3];
      logic [63:0]         vc [3];
      logic signed [31:0]  lr, li, vr, vi;
      logic signed [127:0] acc_re, acc_im;
      scd_pkg::out_word_t  r;
      bit                  clip;
      lk[0] = w.link_0;
      lk[1] = w.link_1;
      lk[2] = w.link_2;
      vc[0] = w.vec_0;
      vc[1] = w.vec_1;
      vc[2] = w.vec_2;
      acc_re = '0;
      acc_im = '0;
      clip   = 1'b0;
      for (int k = 0; k < 3; k++) begin
        lr = lk[k][63:32];
        li = lk[k][31:0];
        vr = vc[k][63:32];
        vi = vc[k][31:0];
        if (adj) begin
          acc_re = acc_re + lr * vr + li * vi;
          acc_im = acc_im + lr * vi - li * vr;
        end else begin
          acc_re = acc_re + lr * vr - li * vi;
          acc_im = acc_im + lr * vi + li * vr;
        end
      end
      r.out_re    = round_clip(acc_re, clip);
      r.out_im    = round_clip(acc_im, clip);
      r.saturated = clip;
      r.last_out  = w.last_item;
      return r;
    endfunction

    function void note_input(scd_pkg::in_word_t w, bit adj);
      expected_q.push_back(su3_dot(w, adj));
    endfunction

    function void check_result(scd_pkg::out_word_t got);
      scd_pkg::out_word_t exp_w;
      if (expected_q.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: re=%h im=%h sat=%b last=%b",
                   got.out_re, got.out_im, got.saturated, got.last_out);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.out_re !== exp_w.out_re || got.out_im !== exp_w.out_im ||
          got.saturated !== exp_w.saturated || got.last_out !== exp_w.last_out) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected re=%h im=%h sat=%b last=%b, ",
                    "got re=%h im=%h sat=%b last=%b"},
                   exp_w.out_re, exp_w.out_im, exp_w.saturated, exp_w.last_out,
                   got.out_re, got.out_im, got.saturated, got.last_out);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void close_out();
      if (expected_q.size() != 0) begin
        failures += expected_q.size();
        $display("%0d result words never arrived", expected_q.size());
      end
    endfunction
  endclass

  dot_scoreboard sb = new();

  su3_complex_dot_product_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] cplx(logic [31:0] re, logic [31:0] im);
    return {re, im};
  endfunction

  // one fixed-point part: often unit-range link values, some full range,
  // some scaled-down random values, extremes and values near the bounds
  function automatic logic [31:0] rand_part();
    int unsigned sel;
    int          s;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: begin
        s = $urandom_range(0, 2 * ONE_I);
        return s - ONE_I;
      end
      4, 5: return $urandom();
      6: begin
        case ($urandom_range(0, 5))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          4:       return ONE_I;
          default: return -ONE_I;
        endcase
      end
      7: return ($urandom_range(0, 1) ? 32'h7fff_0000 : 32'h8000_0000) |
                $urandom_range(0, 16'hffff);
      default: begin
        s = $urandom();
        return s >>> $urandom_range(0, 24);
      end
    endcase
  endfunction

  function automatic scd_pkg::in_word_t rand_word();
    scd_pkg::in_word_t w;
    w.link_0    = cplx(rand_part(), rand_part());
    w.link_1    = cplx(rand_part(), rand_part());
    w.link_2    = cplx(rand_part(), rand_part());
    w.vec_0     = cplx(rand_part(), rand_part());
    w.vec_1     = cplx(rand_part(), rand_part());
    w.vec_2     = cplx(rand_part(), rand_part());
    w.last_item = ($urandom_range(0, 7) == 0);
    return w;
  endfunction

  // offer one word after a random gap and hold it until accepted; the stall
  // is sampled at the falling edge, where it is settled for the next rise
  task automatic send_word(scd_pkg::in_word_t w);
    int unsigned gap;
    bit          taken;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sb.note_input(w, adj_mode);
  endtask

  // stop offering and wait until every expected word is back, plus margin
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LAT + 2) @(posedge clk_i);
  endtask

  // adjoint mode register, written only with the pipeline empty
  task automatic write_adjoint(bit m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    adj_mode = m;
  endtask

  // --------------------------------------------------------------------------
  // output side: random stall per word, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned n;
    bit          got;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        n = LONG_HOLD;
        hold_req = 1'b0;
      end else if (no_idle) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 8);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      // stay open until one result word has gone through
      do begin
        @(negedge clk_i);
        got = out_valid_o;
        @(posedge clk_i);
      end while (!got);
    end
  end

  // result monitor, the word counts as taken at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_result(out_word_o);
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    scd_pkg::in_word_t w;
    scd_pkg::in_word_t directed_q[$];

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_word_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all zero
    w = '0;
    directed_q.push_back(w);
    // all parts at the positive bound, imaginary sum saturates in plain mode, real sum in adjoint
    w.link_0 = {2{32'h7fff_ffff}};
    w.link_1 = w.link_0;
    w.link_2 = w.link_0;
    w.vec_0  = w.link_0;
    w.vec_1  = w.link_0;
    w.vec_2  = w.link_0;
    w.last_item = 1'b1;
    directed_q.push_back(w);
    // all parts at the negative bound
    w.link_0 = {2{32'h8000_0000}};
    w.link_1 = w.link_0;
    w.link_2 = w.link_0;
    w.vec_0  = w.link_0;
    w.vec_1  = w.link_0;
    w.vec_2  = w.link_0;
    w.last_item = 1'b0;
    directed_q.push_back(w);
    // positive links against negative vectors
    w.vec_0 = {2{32'h8000_0000}};
    w.link_0 = {2{32'h7fff_ffff}};
    w.link_1 = w.link_0;
    w.link_2 = w.link_0;
    w.vec_1  = w.vec_0;
    w.vec_2  = w.vec_0;
    w.last_item = 1'b1;
    directed_q.push_back(w);
    // both parts land exactly on the bounds, no clipping
    w = '0;
    w.link_0 = cplx(ONE_I, 0);
    w.vec_0  = cplx(32'h7fff_ffff, 32'h8000_0000);
    directed_q.push_back(w);
    // a half lsb on top of the positive bound tips it over
    w.link_1 = cplx(1, 0);
    w.vec_1  = cplx(HALF_I, 0);
    w.last_item = 1'b1;
    directed_q.push_back(w);
    // positive tie rounds up
    w = '0;
    w.link_0 = cplx(1, 0);
    w.vec_0  = cplx(HALF_I, 0);
    directed_q.push_back(w);
    // negative tie rounds towards plus infinity, sign of im flips in adjoint
    w.link_0 = cplx(1, 1);
    w.vec_0  = cplx(-HALF_I, 0);
    directed_q.push_back(w);
    // just under a tie on both signs
    w.link_0 = cplx(1, 0);
    w.vec_0  = cplx(HALF_I - 1, -HALF_I - 1);
    w.last_item = 1'b1;
    directed_q.push_back(w);
    // purely imaginary link, conjugation flips the real result
    w = '0;
    w.link_2 = cplx(0, ONE_I);
    w.vec_2  = cplx(0, ONE_I);
    directed_q.push_back(w);
    // all ones
    w.link_0 = '1;
    w.link_1 = '1;
    w.link_2 = '1;
    w.vec_0  = '1;
    w.vec_1  = '1;
    w.vec_2  = '1;
    w.last_item = 1'b1;
    directed_q.push_back(w);
    // alternating bit patterns
    w.link_0 = {16{4'ha}};
    w.link_1 = {16{4'h5}};
    w.link_2 = {16{4'ha}};
    w.vec_0  = {16{4'h5}};
    w.vec_1  = {16{4'ha}};
    w.vec_2  = {16{4'h5}};
    w.last_item = 1'b0;
    directed_q.push_back(w);

    // directed words in plain, then in adjoint mode
    write_adjoint(1'b0);
    foreach (directed_q[i]) send_word(directed_q[i]);
    drain_results();
    write_adjoint(1'b1);
    foreach (directed_q[i]) send_word(directed_q[i]);
    drain_results();

    // random phases, each under one mode setting
    for (int ph = 0; ph < 6; ph++) begin
      write_adjoint(PLAN[ph]);
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        // now and then a stretch with no gaps on either side
        if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        // output holds off while words keep coming, so the core backs up
        if (ph == 1 && i == 100) hold_req = 1'b1;
        // sender pauses mid phase until all results are back
        if (ph == 3 && i == 150) drain_results();
        send_word(rand_word());
      end
      no_idle = 1'b0;
      drain_results();
    end

    repeat (4 * LAT) @(posedge clk_i);
    sb.close_out();
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
